// File: hw/rtl/tfn_pkg.sv
// Package for the triangle face normal core: item types, widths and the
// per-stage record of the square-root/divide pipeline. No dependencies.
package tfn_pkg;

  localparam int CW  = 24;   // vertex coordinate
  localparam int EW  = 25;   // edge component
  localparam int PW  = 50;   // edge product
  localparam int XW  = 51;   // cross product component, signed
  localparam int MW  = 50;   // cross magnitude
  localparam int HW  = 25;   // magnitude half
  localparam int SQW = 100;  // squared magnitude
  localparam int LW  = 102;  // squared length
  localparam int AW  = 168;  // residual / accumulator width, signed
  localparam int QW  = 31;   // quotient bits
  localparam int OW  = 32;   // output component
  localparam int NSTEP = 31; // one stage per quotient bit
  localparam int RSH = 62;   // 2^62 scale of the right-hand side

  typedef struct packed {
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] first_z;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic signed [CW-1:0] second_z;
    logic signed [CW-1:0] third_x;
    logic signed [CW-1:0] third_y;
    logic signed [CW-1:0] third_z;
  } in_t;

  typedef struct packed {
    logic signed [OW-1:0] normal_x;
    logic signed [OW-1:0] normal_y;
    logic signed [OW-1:0] normal_z;
    logic                 degenerate;
  } out_t;

  // d = R - t^2*L, p = t*L with t = 2q-1, per component
  typedef struct packed {
    logic                   valid;
    logic                   deg;
    logic [2:0]             neg;
    logic [2:0][QW-1:0]     q;
    logic [2:0][AW-1:0]     d;
    logic [2:0][AW-1:0]     p;
    logic [LW-1:0]          l;
  } step_t;

endpackage

// File: hw/rtl/tfn_root_step.sv
// One quotient-bit stage of the normalize pipeline: decides bit K of all
// three components by an exact residual test. Depends on tfn_pkg.
module tfn_root_step import tfn_pkg::*; #(
  parameter int K = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  step_t s_in,
  output step_t s_out
);

  step_t s_nxt;
  step_t s_r;

  // trial t' = t + 2^(K+1): t'^2 L = t^2 L + 2^(K+2) P + 2^(2K+2) L
  always_comb begin
    logic [AW-1:0]        lx;
    logic signed [AW-1:0] trial;
    s_nxt = s_in;
    lx = {{(AW-LW){1'b0}}, s_in.l};
    for (int i = 0; i < 3; i++) begin
      trial = $signed(s_in.d[i]) - ($signed(s_in.p[i]) <<< (K + 2))
              - $signed(lx << (2 * K + 2));
      if (!trial[AW-1]) begin
        s_nxt.d[i]    = trial;
        s_nxt.p[i]    = s_in.p[i] + (lx << (K + 1));
        s_nxt.q[i][K] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.valid <= 1'b0;
    end else if (en) begin
      s_r <= s_nxt;
    end
  end

  assign s_out = s_r;

endmodule

// File: hw/rtl/triangle_face_normal_core.sv
// Triangle face normal core: edges, cross product, exact unit normal (Q2.30).
// An 8-stage edge/cross/square front end, 31 quotient-bit stages and the
// output register; one item per cycle while out_stall does not hold it.
// The whole pipeline holds while a finished item waits under out_stall.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// Depends on tfn_pkg and tfn_root_step.
module triangle_face_normal_core import tfn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic en;
  logic [6:0] v_r;

  logic signed [EW-1:0] a_r [3];
  logic signed [EW-1:0] b_r [3];
  logic signed [PW-1:0] pr_r [6];
  logic signed [XW-1:0] c_r [3];
  logic [MW-1:0]        m_r [3];
  logic [2:0]           neg4_r, neg5_r, neg6_r, neg7_r;
  logic [PW-1:0]        hh_r [3];
  logic [PW-1:0]        hl_r [3];
  logic [PW-1:0]        ll_r [3];
  logic [SQW-1:0]       sq_r [3];
  logic [SQW-1:0]       sq7_r [3];
  logic [LW-1:0]        l_r;
  step_t                st0_nxt, st0_r;
  step_t                st [NSTEP+1];
  out_t                 out_nxt, out_r;
  logic                 out_valid_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // valid bits of the front end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  // front end datapath: edges, products, cross, magnitude, square, length
  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= EW'(in_data.first_x) - EW'(in_data.second_x);
      a_r[1] <= EW'(in_data.first_y) - EW'(in_data.second_y);
      a_r[2] <= EW'(in_data.first_z) - EW'(in_data.second_z);
      b_r[0] <= EW'(in_data.first_x) - EW'(in_data.third_x);
      b_r[1] <= EW'(in_data.first_y) - EW'(in_data.third_y);
      b_r[2] <= EW'(in_data.first_z) - EW'(in_data.third_z);

      pr_r[0] <= a_r[1] * b_r[2];
      pr_r[1] <= b_r[1] * a_r[2];
      pr_r[2] <= b_r[0] * a_r[2];
      pr_r[3] <= a_r[0] * b_r[2];
      pr_r[4] <= a_r[0] * b_r[1];
      pr_r[5] <= b_r[0] * a_r[1];

      for (int i = 0; i < 3; i++) begin
        c_r[i] <= XW'(pr_r[2*i]) - XW'(pr_r[2*i+1]);
      end

      for (int i = 0; i < 3; i++) begin
        m_r[i]    <= c_r[i][XW-1] ? MW'(-c_r[i]) : MW'(c_r[i]);
        neg4_r[i] <= c_r[i][XW-1];
      end

      // 50x50 square as three 25x25 partial products
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= PW'(m_r[i][MW-1:HW] * m_r[i][MW-1:HW]);
        hl_r[i] <= PW'(m_r[i][MW-1:HW] * m_r[i][HW-1:0]);
        ll_r[i] <= PW'(m_r[i][HW-1:0] * m_r[i][HW-1:0]);
      end
      neg5_r <= neg4_r;

      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= {hh_r[i], {PW{1'b0}}} + {{(SQW-PW-HW-1){1'b0}}, hl_r[i], {(HW+1){1'b0}}}
                   + {{(SQW-PW){1'b0}}, ll_r[i]};
      end
      neg6_r <= neg5_r;

      l_r <= {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};
      for (int i = 0; i < 3; i++) begin
        sq7_r[i] <= sq_r[i];
      end
      neg7_r <= neg6_r;
    end
  end

  // initial record: q = 0, t = -1, d = R - L, p = -L
  always_comb begin
    logic [AW-1:0] lx;
    lx = {{(AW-LW){1'b0}}, l_r};
    st0_nxt.valid = v_r[6];
    st0_nxt.deg   = (l_r == '0);
    st0_nxt.neg   = neg7_r;
    st0_nxt.l     = l_r;
    for (int i = 0; i < 3; i++) begin
      st0_nxt.q[i] = '0;
      st0_nxt.d[i] = {{(AW-SQW-RSH){1'b0}}, sq7_r[i], {RSH{1'b0}}} - lx;
      st0_nxt.p[i] = -lx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st0_r.valid <= 1'b0;
    end else if (en) begin
      st0_r <= st0_nxt;
    end
  end

  assign st[0] = st0_r;

  // one stage per quotient bit, most significant first
  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    tfn_root_step #(.K(NSTEP - 1 - j)) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .s_in  (st[j]),
      .s_out (st[j+1])
    );
  end

  // sign, degenerate case, output register
  always_comb begin
    logic [OW-1:0] qv [3];
    for (int i = 0; i < 3; i++) begin
      qv[i] = {1'b0, st[NSTEP].q[i]};
      if (st[NSTEP].deg) begin
        qv[i] = '0;
      end else if (st[NSTEP].neg[i]) begin
        qv[i] = -qv[i];
      end
    end
    out_nxt.normal_x   = qv[0];
    out_nxt.normal_y   = qv[1];
    out_nxt.normal_z   = qv[2];
    out_nxt.degenerate = st[NSTEP].deg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= st[NSTEP].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
